FILE: rtl/gmm_min_component_cost_macros.svh
// ----------------------------------------------------------------------------
// GMM minimum component cost: assertion macros
// Concurrent assertion shorthands for the block's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef GMM_MIN_COMPONENT_COST_MACROS_SVH
`define GMM_MIN_COMPONENT_COST_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define GMM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent
`define GMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/gmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GMM minimum component cost: shared package
// Sizes, table word codes, cluster entry layout and the cost pipeline tag.
// ----------------------------------------------------------------------------
package gmm_pkg;

    // Number of mixture components held in the cell ring
    localparam int MAX_CLUSTERS = 8;
    localparam int CLUSTER_W    = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int CFG_W        = 4;
    localparam int CMP_W        = (CLUSTER_W > CFG_W) ? CLUSTER_W : CFG_W;

    typedef logic [CLUSTER_W-1:0] cnt_t;
    typedef logic [CMP_W-1:0]     cmp_t;

    // Arithmetic widths
    typedef logic signed [16:0] diff_t;   // Q8.8 colour difference
    typedef logic signed [33:0] dprod_t;  // product of two differences
    typedef logic signed [63:0] term_t;   // coefficient times difference product
    typedef logic signed [64:0] pair_t;   // sum of two terms
    typedef logic signed [66:0] sum_t;    // sum of six terms
    typedef logic signed [47:0] cost_t;   // Q32.16 cost
    typedef logic signed [48:0] wcost_t;  // cost before saturation

    localparam int FRAC_DROP = 24;
    localparam int NUM_TERMS = 6;

    localparam cost_t COST_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam cost_t COST_MIN = 48'sh8000_0000_0000;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd5;

    // Input item actions
    localparam logic ACT_EVAL = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    // Table word selects
    localparam logic [3:0] SEL_CENTRE_R   = 4'd0;
    localparam logic [3:0] SEL_CENTRE_B   = 4'd2;
    localparam logic [3:0] SEL_COEF_FIRST = 4'd3;
    localparam logic [3:0] SEL_COEF_LAST  = 4'd8;
    localparam logic [3:0] SEL_BIAS       = 4'd9;

    // Difference pairs of the quadratic form: rr, rg, rb, gg, gb, bb
    localparam logic [1:0] TERM_A [NUM_TERMS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam logic [1:0] TERM_B [NUM_TERMS] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

    // One cluster's table: centres Q8.8, coefficients Q8.24, bias Q32.16
    typedef struct packed {
        logic [2:0][15:0] centre;
        logic [5:0][31:0] coef;
        logic [47:0]      bias;
    } entry_t;

    // Control tag travelling with each cluster through the cost pipeline
    typedef struct packed {
        logic valid;
        logic active;
        logic last;
    } tag_t;

endpackage

FILE: rtl/gmm_min_component_cost.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GMM minimum component cost: top level
// Smallest Gaussian-mixture component cost of one RGB pixel over a ring of
// cluster cells, with a shared six-stage cost pipeline at the ring head.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) takes two kinds of beat. A load
//   beat (action = 1) writes one table word of one cluster and is taken
//   without raising in_stall; it returns nothing. An evaluate beat (action = 0)
//   returns one min_cost beat on the output channel (out_valid / out_stall).
//   An evaluation rotates the ring of MAX_CLUSTERS cells once, one cluster
//   per cycle into the cost pipeline, then drains the six pipeline stages.
//   The next item is taken only once the ring rotation and the pipeline
//   drain are through and the result has moved to the output register.
//   in_stall is high from an evaluate beat until its result sits in the
//   output register; a stalled receiver holds that register, while the next
//   item may already be taken. Only a second result waits for the register.
//   Reset empties the output, returns the control to idle and sets
//   active_clusters to 5; the cluster table is undefined until loaded.
//   Write cfg_wr_data through cfg_wr_en only while the block is idle.
// ----------------------------------------------------------------------------
`include "gmm_min_component_cost_macros.svh"

module gmm_min_component_cost (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [2:0]  cluster_slot,
    input  logic [3:0]  word_select,
    input  logic [47:0] word_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [47:0] min_cost
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [gmm_pkg::CFG_W-1:0] active_clusters_reg;
    gmm_pkg::cnt_t  issue_cnt_reg, issue_cnt_next;
    logic [7:0]     red_reg, green_reg, blue_reg;
    gmm_pkg::cost_t best_reg;
    logic           out_valid_reg;
    gmm_pkg::cost_t min_cost_reg;

    logic           in_beat, eval_beat, load_beat;
    logic           issuing, last_issue, out_free;
    logic [gmm_pkg::MAX_CLUSTERS-1:0] load_en;
    gmm_pkg::entry_t ring [gmm_pkg::MAX_CLUSTERS];
    gmm_pkg::tag_t  tag_issue, tag_cost;
    gmm_pkg::cost_t cost;

    assign in_beat    = in_valid && !in_stall;
    assign eval_beat  = in_beat && (action == gmm_pkg::ACT_EVAL);
    assign load_beat  = in_beat && (action == gmm_pkg::ACT_LOAD);
    assign issuing    = (state_reg == ST_ISSUE);
    assign last_issue = (issue_cnt_reg == gmm_pkg::cnt_t'(gmm_pkg::MAX_CLUSTERS - 1));
    assign out_free   = !out_valid_reg || !out_stall;

    // Ring of cluster cells, rotating toward cell 0 while issuing
    for (genvar k = 0; k < gmm_pkg::MAX_CLUSTERS; k++)
    begin : g_cell
        assign load_en[k] = load_beat
                          && (gmm_pkg::cmp_t'(cluster_slot) == gmm_pkg::cmp_t'(k));

        gmm_cell u_cell (
            .clk         (clk),
            .shift_en    (issuing),
            .entry_in    (ring[(k + 1) % gmm_pkg::MAX_CLUSTERS]),
            .load_en     (load_en[k]),
            .word_select (word_select),
            .word_value  (word_value),
            .entry_out   (ring[k])
        );
    end

    // Tag the cluster at the ring head; cluster 0 always counts
    always_comb
    begin
        tag_issue.valid  = issuing;
        tag_issue.active = (gmm_pkg::cmp_t'(issue_cnt_reg)
                            < gmm_pkg::cmp_t'(active_clusters_reg))
                         || (issue_cnt_reg == '0);
        tag_issue.last   = last_issue;
    end

    gmm_cost_pipe u_cost_pipe (
        .clk     (clk),
        .rst_n   (rst_n),
        .entry   (ring[0]),
        .red     (red_reg),
        .green   (green_reg),
        .blue    (blue_reg),
        .tag_in  (tag_issue),
        .tag_out (tag_cost),
        .cost    (cost)
    );

    // Sequence one evaluation
    always_comb
    begin
        state_next     = state_reg;
        issue_cnt_next = issue_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                issue_cnt_next = '0;
                if (eval_beat)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                issue_cnt_next = issue_cnt_reg + 1'b1;
                if (last_issue)
                begin
                    issue_cnt_next = '0;
                    state_next     = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (tag_cost.valid && tag_cost.last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next     = ST_IDLE;
                issue_cnt_next = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            issue_cnt_reg       <= '0;
            active_clusters_reg <= gmm_pkg::ACTIVE_RESET;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            if (cfg_wr_en)
            begin
                active_clusters_reg <= cfg_wr_data;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the pixel, track the running minimum, load the output beat
    always_ff @(posedge clk)
    begin
        if (eval_beat)
        begin
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
            best_reg  <= gmm_pkg::COST_MAX;
        end
        else if (tag_cost.valid && tag_cost.active && (cost < best_reg))
        begin
            best_reg <= cost;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            min_cost_reg <= best_reg;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign min_cost  = min_cost_reg;

    `GMM_ASSERT_NEXT(a_eval_starts_issue, clk, rst_n, eval_beat, state_reg == ST_ISSUE, "evaluate beat did not start the ring rotation")
    `GMM_ASSERT_SAME(a_cost_only_in_run, clk, rst_n, tag_cost.valid, state_reg == ST_ISSUE || state_reg == ST_DRAIN, "cost left the pipeline outside an evaluation")
    `GMM_ASSERT_NEXT(a_last_cost_done, clk, rst_n, tag_cost.valid && tag_cost.last, state_reg == ST_DONE, "last cluster cost did not finish the evaluation")
    `GMM_ASSERT_NEXT(a_done_delivers, clk, rst_n, state_reg == ST_DONE && out_free, out_valid_reg && state_reg == ST_IDLE, "finished result was not moved to the output")

endmodule

FILE: rtl/gmm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GMM cell: one cluster table in the rotating ring
// Holds one cluster entry, takes table loads while at rest and hands its
// entry to the neighbor on every rotation step.
// ----------------------------------------------------------------------------
module gmm_cell (
    input  logic           clk,
    input  logic           shift_en,
    input  gmm_pkg::entry_t entry_in,
    input  logic           load_en,
    input  logic [3:0]     word_select,
    input  logic [47:0]    word_value,
    output gmm_pkg::entry_t entry_out
);

    gmm_pkg::entry_t entry_reg;
    gmm_pkg::entry_t entry_next;
    logic [3:0]      coef_idx;

    // Rotate, or write the selected table word
    always_comb
    begin
        entry_next = entry_reg;
        coef_idx   = word_select - gmm_pkg::SEL_COEF_FIRST;
        if (shift_en)
        begin
            entry_next = entry_in;
        end
        else if (load_en)
        begin
            unique case (word_select) inside
                [gmm_pkg::SEL_CENTRE_R:gmm_pkg::SEL_CENTRE_B]:
                    entry_next.centre[word_select[1:0]] = word_value[15:0];
                [gmm_pkg::SEL_COEF_FIRST:gmm_pkg::SEL_COEF_LAST]:
                    entry_next.coef[coef_idx[2:0]] = word_value[31:0];
                gmm_pkg::SEL_BIAS:
                    entry_next.bias = word_value;
                default:
                    entry_next = entry_reg;
            endcase
        end
    end

    // Table storage has no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry_out = entry_reg;

endmodule

FILE: rtl/gmm_cost_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GMM cost pipeline: quadratic form plus bias for one cluster per cycle
// Six stages: difference, difference product, coefficient product, pair sum,
// total, floor to Q.16 with bias and saturation.
// ----------------------------------------------------------------------------
module gmm_cost_pipe (
    input  logic            clk,
    input  logic            rst_n,
    input  gmm_pkg::entry_t entry,
    input  logic [7:0]      red,
    input  logic [7:0]      green,
    input  logic [7:0]      blue,
    input  gmm_pkg::tag_t   tag_in,
    output gmm_pkg::tag_t   tag_out,
    output gmm_pkg::cost_t  cost
);

    logic [7:0]  pix [3];
    logic [17:0] diff_wide [3];

    // Stage registers
    gmm_pkg::tag_t  tag_s1_reg, tag_s2_reg, tag_s3_reg, tag_s4_reg, tag_s5_reg, tag_s6_reg;
    gmm_pkg::diff_t d_reg [3];
    gmm_pkg::diff_t d_next [3];
    logic [5:0][31:0] coef_s1_reg, coef_s2_reg;
    logic [47:0]    bias_s1_reg, bias_s2_reg, bias_s3_reg, bias_s4_reg, bias_s5_reg;
    gmm_pkg::dprod_t dd_reg [gmm_pkg::NUM_TERMS];
    gmm_pkg::dprod_t dd_next [gmm_pkg::NUM_TERMS];
    logic signed [65:0] prod [gmm_pkg::NUM_TERMS];
    gmm_pkg::term_t t_reg [gmm_pkg::NUM_TERMS];
    gmm_pkg::term_t t_next [gmm_pkg::NUM_TERMS];
    gmm_pkg::pair_t pair_reg [3];
    gmm_pkg::pair_t pair_next [3];
    gmm_pkg::sum_t  total_reg;
    gmm_pkg::sum_t  total_next;
    logic signed [42:0] floor_q16;
    gmm_pkg::wcost_t cost_wide;
    gmm_pkg::cost_t  cost_reg;
    gmm_pkg::cost_t  cost_next;

    assign pix[0] = red;
    assign pix[1] = green;
    assign pix[2] = blue;

    // Form colour differences against the cluster centre
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff_wide[i] = {2'b00, pix[i], 8'h00} - {2'b00, entry.centre[i]};
            d_next[i]    = gmm_pkg::diff_t'(diff_wide[i][16:0]);
        end
    end

    // Multiply difference pairs, then coefficients
    always_comb
    begin
        for (int j = 0; j < gmm_pkg::NUM_TERMS; j++)
        begin
            dd_next[j] = d_reg[gmm_pkg::TERM_A[j]] * d_reg[gmm_pkg::TERM_B[j]];
            prod[j]    = $signed(coef_s2_reg[j]) * dd_reg[j];
            t_next[j]  = gmm_pkg::term_t'(prod[j][63:0]);
        end
    end

    // Sum the six terms over two stages
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pair_next[i] = gmm_pkg::pair_t'(t_reg[2*i]) + gmm_pkg::pair_t'(t_reg[2*i+1]);
        end
        total_next = gmm_pkg::sum_t'(pair_reg[0]) + gmm_pkg::sum_t'(pair_reg[1])
                   + gmm_pkg::sum_t'(pair_reg[2]);
    end

    // Floor to Q.16, add bias, saturate
    always_comb
    begin
        floor_q16 = total_reg[66:gmm_pkg::FRAC_DROP];
        cost_wide = gmm_pkg::wcost_t'(floor_q16)
                  + gmm_pkg::wcost_t'($signed(bias_s5_reg));
        if (cost_wide > gmm_pkg::wcost_t'(gmm_pkg::COST_MAX))
        begin
            cost_next = gmm_pkg::COST_MAX;
        end
        else if (cost_wide < gmm_pkg::wcost_t'(gmm_pkg::COST_MIN))
        begin
            cost_next = gmm_pkg::COST_MIN;
        end
        else
        begin
            cost_next = gmm_pkg::cost_t'(cost_wide[47:0]);
        end
    end

    // Advance the control tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_s1_reg <= '0;
            tag_s2_reg <= '0;
            tag_s3_reg <= '0;
            tag_s4_reg <= '0;
            tag_s5_reg <= '0;
            tag_s6_reg <= '0;
        end
        else
        begin
            tag_s1_reg <= tag_in;
            tag_s2_reg <= tag_s1_reg;
            tag_s3_reg <= tag_s2_reg;
            tag_s4_reg <= tag_s3_reg;
            tag_s5_reg <= tag_s4_reg;
            tag_s6_reg <= tag_s5_reg;
        end
    end

    // Advance the data path
    always_ff @(posedge clk)
    begin
        d_reg       <= d_next;
        coef_s1_reg <= entry.coef;
        bias_s1_reg <= entry.bias;
        dd_reg      <= dd_next;
        coef_s2_reg <= coef_s1_reg;
        bias_s2_reg <= bias_s1_reg;
        t_reg       <= t_next;
        bias_s3_reg <= bias_s2_reg;
        pair_reg    <= pair_next;
        bias_s4_reg <= bias_s3_reg;
        total_reg   <= total_next;
        bias_s5_reg <= bias_s4_reg;
        cost_reg    <= cost_next;
    end

    assign tag_out = tag_s6_reg;
    assign cost    = cost_reg;

endmodule

FILE: tb/gmm_min_component_cost_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GMM minimum component cost: testbench
// Loads the cluster table, then sends directed and random pixel and load beats
// through the valid/stall input, predicts each minimum cost with a cost model
// of its own, and checks every min_cost beat in order under random stalls.
// ----------------------------------------------------------------------------
module gmm_min_component_cost_tb;
    import gmm_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int SETTLE_CYCLES = MAX_CLUSTERS + 16;
    localparam int IDLE_PCT      = 11;
    localparam int SEGMENT_BEATS = 160;
    localparam int SEGMENTS      = 7;
    localparam int EVAL_PCT      = 70;

    // Highest code the select field can carry; codes above the bias are unused
    localparam logic [3:0] SEL_CODE_TOP = 4'd15;

    typedef struct packed {
        logic        action;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [2:0]  slot;
        logic [3:0]  sel;
        logic [47:0] value;
    } beat_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic [3:0]  cfg_wr_data  = '0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic        action       = ACT_EVAL;
    logic [7:0]  red          = '0;
    logic [7:0]  green        = '0;
    logic [7:0]  blue         = '0;
    logic [2:0]  cluster_slot = '0;
    logic [3:0]  word_select  = '0;
    logic [47:0] word_value   = '0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [47:0] min_cost;

    // Cost model state: cluster table and the searched cluster count
    logic [15:0]        centre_tbl [MAX_CLUSTERS][3];
    logic signed [31:0] coef_tbl   [MAX_CLUSTERS][6];
    logic signed [47:0] bias_tbl   [MAX_CLUSTERS];
    logic [3:0]         cluster_limit = ACTIVE_RESET;

    logic [47:0] pending_costs [$];
    logic [47:0] want_cost;
    int          errors = 0;
    logic        steady = 1'b0;

    gmm_min_component_cost u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .cluster_slot (cluster_slot),
        .word_select  (word_select),
        .word_value   (word_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .min_cost     (min_cost)
    );

    always #CLK_HALF clk = ~clk;

    // Cost of one cluster, exact sum of the six terms, floored to Q.16, biased and saturated
    function automatic logic signed [79:0] component_cost(input int k, input beat_t b);
        logic signed [79:0] dr, dg, db, quad, cost;
        logic signed [79:0] c [6];
        dr = $signed({1'b0, b.red, 8'h00}) - $signed({1'b0, centre_tbl[k][0]});
        dg = $signed({1'b0, b.green, 8'h00}) - $signed({1'b0, centre_tbl[k][1]});
        db = $signed({1'b0, b.blue, 8'h00}) - $signed({1'b0, centre_tbl[k][2]});
        for (int i = 0; i < 6; i++)
        begin
            c[i] = coef_tbl[k][i];
        end
        quad = c[0] * dr * dr + c[1] * dr * dg + c[2] * dr * db
             + c[3] * dg * dg + c[4] * dg * db + c[5] * db * db;
        cost = (quad >>> FRAC_DROP) + bias_tbl[k];
        if (cost > COST_MAX)
            cost = COST_MAX;
        else if (cost < COST_MIN)
            cost = COST_MIN;
        return cost;
    endfunction

    // Smallest cost over the searched clusters, count clamped to 1..MAX_CLUSTERS
    function automatic logic [47:0] pixel_min_cost(input beat_t b);
        int n;
        logic signed [79:0] best, c;
        if (cluster_limit == 0)
            n = 1;
        else if (cluster_limit > MAX_CLUSTERS)
            n = MAX_CLUSTERS;
        else
            n = cluster_limit;
        best = COST_MAX;
        for (int k = 0; k < n; k++)
        begin
            c = component_cost(k, b);
            if (c < best)
                best = c;
        end
        return best[47:0];
    endfunction

    // Update the table on a load, queue the expected cost on an evaluation
    function automatic void apply_beat(input beat_t b);
        if (b.action == ACT_LOAD)
        begin
            if (b.slot < MAX_CLUSTERS)
            begin
                if (b.sel <= SEL_CENTRE_B)
                    centre_tbl[b.slot][b.sel - SEL_CENTRE_R] = b.value[15:0];
                else if (b.sel <= SEL_COEF_LAST)
                    coef_tbl[b.slot][b.sel - SEL_COEF_FIRST] = b.value[31:0];
                else if (b.sel == SEL_BIAS)
                    bias_tbl[b.slot] = b.value;
            end
        end
        else
        begin
            pending_costs = {pending_costs, pixel_min_cost(b)};
        end
    endfunction

    function automatic logic [47:0] rand48();
        return {16'($urandom()), $urandom()};
    endfunction

    // Beat with every field random
    function automatic beat_t random_beat();
        logic [95:0] noise;
        noise = {$urandom(), $urandom(), $urandom()};
        return noise[$bits(beat_t)-1:0];
    endfunction

    // Table word: mostly small coefficients and moderate biases, junk in unused bits
    function automatic logic [47:0] table_word(input logic [3:0] sel);
        logic [47:0] w;
        w = rand48();
        if (sel >= SEL_COEF_FIRST && sel <= SEL_COEF_LAST && $urandom_range(0, 3) != 0)
            w[31:0] = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        else if (sel == SEL_BIAS && $urandom_range(0, 7) != 0)
            w = {{8{w[39]}}, w[39:0]};
        return w;
    endfunction

    // Drive one beat at the falling edge, hold it until taken
    task automatic send_beat(input beat_t b);
        @(negedge clk);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid     <= 1'b1;
        action       <= b.action;
        red          <= b.red;
        green        <= b.green;
        blue         <= b.blue;
        cluster_slot <= b.slot;
        word_select  <= b.sel;
        word_value   <= b.value;
        do
            @(posedge clk);
        while (in_stall);
        apply_beat(b);
    endtask

    task automatic load_word(input int slot, input int sel, input logic [47:0] value);
        beat_t b;
        b        = random_beat();
        b.action = ACT_LOAD;
        b.slot   = 3'(slot);
        b.sel    = 4'(sel);
        b.value  = value;
        send_beat(b);
    endtask

    task automatic eval_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] bl);
        beat_t b;
        b        = random_beat();
        b.action = ACT_EVAL;
        b.red    = r;
        b.green  = g;
        b.blue   = bl;
        send_beat(b);
    endtask

    // Drop valid, wait for every expected cost, then let the block go idle
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_costs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cluster_limit(input logic [3:0] v);
        settle();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        cluster_limit = v;
    endtask

    task automatic load_table();
        for (int k = 0; k < MAX_CLUSTERS; k++)
        begin
            for (int s = SEL_CENTRE_R; s <= SEL_BIAS; s++)
            begin
                load_word(k, s, table_word(4'(s)));
            end
        end
    endtask

    // Fill every cluster, then evaluate at the reset cluster count
    task automatic test_table_load();
        load_table();
        eval_pixel(8'h00, 8'h00, 8'h00);
        eval_pixel(8'hFF, 8'hFF, 8'hFF);
        eval_pixel(8'hAA, 8'h55, 8'hF0);
    endtask

    // Saturate both ways, and floor a tiny negative sum
    task automatic test_saturation();
        write_cluster_limit(4'd1);
        for (int ch = 0; ch < 3; ch++)
            load_word(0, SEL_CENTRE_R + ch, 48'h0000_0000_FFFF);
        for (int i = 0; i < 6; i++)
            load_word(0, SEL_COEF_FIRST + i, 48'h0000_7FFF_FFFF);
        load_word(0, SEL_BIAS, COST_MAX);
        eval_pixel(8'h00, 8'h00, 8'h00);

        for (int i = 0; i < 6; i++)
            load_word(0, SEL_COEF_FIRST + i, 48'h0000_8000_0000);
        load_word(0, SEL_BIAS, COST_MIN);
        eval_pixel(8'h00, 8'h00, 8'h00);
        for (int ch = 0; ch < 3; ch++)
            load_word(0, SEL_CENTRE_R + ch, 48'h0);
        eval_pixel(8'hFF, 8'hFF, 8'hFF);

        // Differences of one LSB with coefficients of minus one LSB
        for (int ch = 0; ch < 3; ch++)
            load_word(0, SEL_CENTRE_R + ch, 48'h0000_0000_1001);
        for (int i = 0; i < 6; i++)
            load_word(0, SEL_COEF_FIRST + i, 48'hFFFF_FFFF_FFFF);
        load_word(0, SEL_BIAS, 48'h0);
        eval_pixel(8'h10, 8'h10, 8'h10);
        eval_pixel(8'hFF, 8'h00, 8'h10);
        for (int i = 0; i < 6; i++)
            load_word(0, SEL_COEF_FIRST + i, 48'h0000_0000_0001);
        eval_pixel(8'h10, 8'h10, 8'h10);
    endtask

    // Truncation of narrow words and the unused select codes
    task automatic test_load_formats();
        load_word(0, SEL_CENTRE_R, 48'hABCD_EF01_2345);
        load_word(0, SEL_COEF_FIRST, 48'h1357_8000_0001);
        for (int i = 1; i < 6; i++)
            load_word(0, SEL_COEF_FIRST + i, 48'hFFFF_0000_0000);
        load_word(0, SEL_BIAS, 48'h0000_1234_5678);
        for (int s = SEL_BIAS + 1; s <= SEL_CODE_TOP; s++)
            load_word(0, s, rand48());
        eval_pixel(8'h80, 8'h40, 8'h20);
    endtask

    // Later clusters cheaper, so the result shows how many were searched
    task automatic test_cluster_count();
        logic [3:0] limits [7];
        limits = '{4'd0, 4'd1, 4'd2, 4'd8, 4'd9, 4'd15, ACTIVE_RESET};
        for (int k = 0; k < MAX_CLUSTERS; k++)
        begin
            for (int i = 0; i < 6; i++)
                load_word(k, SEL_COEF_FIRST + i, 48'h0);
            load_word(k, SEL_BIAS, 48'(MAX_CLUSTERS - k) << 16);
        end
        for (int j = 0; j < 7; j++)
        begin
            write_cluster_limit(limits[j]);
            eval_pixel(8'($urandom()), 8'($urandom()), 8'($urandom()));
        end
    endtask

    // Random pixels and table rewrites across several cluster counts
    task automatic test_random();
        beat_t b;
        logic [3:0] limits [SEGMENTS];
        limits = '{4'd8, 4'd0, 4'd15, 4'd1, 4'($urandom()), 4'd9, 4'($urandom())};
        load_table();
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            write_cluster_limit(limits[seg]);
            steady = (seg == 3);
            for (int n = 0; n < SEGMENT_BEATS; n++)
            begin
                b = random_beat();
                if ($urandom_range(0, 99) < EVAL_PCT)
                begin
                    b.action = ACT_EVAL;
                end
                else
                begin
                    b.action = ACT_LOAD;
                    if ($urandom_range(0, 7) == 0)
                    begin
                        b.sel = 4'($urandom_range(SEL_BIAS + 1, SEL_CODE_TOP));
                    end
                    else
                    begin
                        b.sel   = 4'($urandom_range(SEL_CENTRE_R, SEL_BIAS));
                        b.value = table_word(b.sel);
                    end
                end
                send_beat(b);
            end
            steady = 1'b0;
        end
    endtask

    // Stall the result side at random, except in the steady stretch
    always @(negedge clk)
    begin
        out_stall <= rst_n && !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Check each taken result against the oldest expected cost
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_costs.size() == 0)
            begin
                $display("%0t ns: min_cost expected none actual %h", $time, min_cost);
                errors++;
            end
            else
            begin
                want_cost = pending_costs.pop_front();
                if (min_cost !== want_cost)
                begin
                    $display("%0t ns: min_cost expected %h actual %h",
                             $time, want_cost, min_cost);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_table_load();
        test_saturation();
        test_load_formats();
        test_cluster_count();
        test_random();
        settle();
        if (errors == 0)
            $display("gmm_min_component_cost_tb OK");
        else
            $display("gmm_min_component_cost_tb NOT OK");
        $finish;
    end

    // Give up on a hung run
    initial
    begin
        #5_000_000;
        $display("gmm_min_component_cost_tb NOT OK");
        $finish;
    end

endmodule
